// ===== rtl/itp_pkg.sv =====
package itp_pkg;

    // Token kinds handed from the front end to the back end
    typedef enum logic [2:0] {
        TK_NONE,
        TK_LETTER,
        TK_OPEN,
        TK_OP,
        TK_CLOSE
    } tok_kind_t;

    // Stack entry codes
    localparam logic [2:0] CODE_EMPTY = 3'd0;
    localparam logic [2:0] CODE_OPEN  = 3'd1;
    localparam logic [2:0] CODE_PLUS  = 3'd2;
    localparam logic [2:0] CODE_MINUS = 3'd3;
    localparam logic [2:0] CODE_MUL   = 3'd4;
    localparam logic [2:0] CODE_DIV   = 3'd5;
    localparam logic [2:0] CODE_POW   = 3'd6;

    // ASCII characters
    localparam logic [7:0] CHAR_NUL   = 8'h00;
    localparam logic [7:0] CHAR_OPEN  = 8'h28;
    localparam logic [7:0] CHAR_CLOSE = 8'h29;
    localparam logic [7:0] CHAR_MUL   = 8'h2A;
    localparam logic [7:0] CHAR_PLUS  = 8'h2B;
    localparam logic [7:0] CHAR_MINUS = 8'h2D;
    localparam logic [7:0] CHAR_DIV   = 8'h2F;
    localparam logic [7:0] CHAR_UA    = 8'h41;
    localparam logic [7:0] CHAR_UZ    = 8'h5A;
    localparam logic [7:0] CHAR_POW   = 8'h5E;
    localparam logic [7:0] CHAR_LA    = 8'h61;
    localparam logic [7:0] CHAR_LZ    = 8'h7A;

    // Result status codes
    localparam logic [1:0] STATUS_OK        = 2'd0;
    localparam logic [1:0] STATUS_BAD_CLOSE = 2'd1;
    localparam logic [1:0] STATUS_BAD_OPEN  = 2'd2;
    localparam logic [1:0] STATUS_OVERFLOW  = 2'd3;

    // Token queue depth
    localparam int QUEUE_DEPTH = 4;

    typedef struct packed {
        tok_kind_t   kind;
        logic [7:0]  ch;
        logic [2:0]  code;
        logic        eoe;
    } token_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MAIN,
        ST_FLUSH,
        ST_DONE
    } back_state_t;

    function automatic logic [7:0] code_char(input logic [2:0] code);
        logic [7:0] c;
        case (code)
            CODE_OPEN:  c = CHAR_OPEN;
            CODE_PLUS:  c = CHAR_PLUS;
            CODE_MINUS: c = CHAR_MINUS;
            CODE_MUL:   c = CHAR_MUL;
            CODE_DIV:   c = CHAR_DIV;
            CODE_POW:   c = CHAR_POW;
            default:    c = CHAR_NUL;
        endcase
        return c;
    endfunction

    function automatic logic [1:0] code_prec(input logic [2:0] code);
        logic [1:0] p;
        case (code)
            CODE_PLUS, CODE_MINUS: p = 2'd1;
            CODE_MUL, CODE_DIV:    p = 2'd2;
            CODE_POW:              p = 2'd3;
            default:               p = 2'd0;
        endcase
        return p;
    endfunction

endpackage

// ===== rtl/itp_if.sv =====
// Infix character channel
interface itp_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_char;
    logic       end_of_expr;

    modport source (output valid, output in_char, output end_of_expr, input ready);
    modport sink (input valid, input in_char, input end_of_expr, output ready);
endinterface

// Postfix result channel
interface itp_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_char;
    logic       char_valid;
    logic [1:0] status;
    logic       last;

    modport source (output valid, output out_char, output char_valid, output status,
                    output last, input ready);
    modport sink (input valid, input out_char, input char_valid, input status,
                  input last, output ready);
endinterface

// ===== rtl/itp_front.sv =====
module itp_front (
    itp_in_if.sink          infix,
    input  logic            q_full,
    output logic            q_push,
    output itp_pkg::token_t q_token
);

    // Map an operator character to its stack code
    function automatic logic [2:0] op_code(input logic [7:0] c);
        logic [2:0] code;
        case (c)
            itp_pkg::CHAR_PLUS:  code = itp_pkg::CODE_PLUS;
            itp_pkg::CHAR_MINUS: code = itp_pkg::CODE_MINUS;
            itp_pkg::CHAR_MUL:   code = itp_pkg::CODE_MUL;
            itp_pkg::CHAR_DIV:   code = itp_pkg::CODE_DIV;
            itp_pkg::CHAR_POW:   code = itp_pkg::CODE_POW;
            default:             code = itp_pkg::CODE_EMPTY;
        endcase
        return code;
    endfunction

    logic [2:0] cur_code;
    logic       is_letter;

    // Classify the incoming character
    always_comb
    begin
        cur_code  = op_code(infix.in_char);
        is_letter = ((infix.in_char >= itp_pkg::CHAR_UA) && (infix.in_char <= itp_pkg::CHAR_UZ))
                 || ((infix.in_char >= itp_pkg::CHAR_LA) && (infix.in_char <= itp_pkg::CHAR_LZ));

        q_token.ch   = infix.in_char;
        q_token.code = cur_code;
        q_token.eoe  = infix.end_of_expr;
        if (is_letter)
        begin
            q_token.kind = itp_pkg::TK_LETTER;
        end
        else if (infix.in_char == itp_pkg::CHAR_OPEN)
        begin
            q_token.kind = itp_pkg::TK_OPEN;
        end
        else if (cur_code != itp_pkg::CODE_EMPTY)
        begin
            q_token.kind = itp_pkg::TK_OP;
        end
        else if (infix.in_char == itp_pkg::CHAR_CLOSE)
        begin
            q_token.kind = itp_pkg::TK_CLOSE;
        end
        else
        begin
            q_token.kind = itp_pkg::TK_NONE;
        end
    end

    // Ignored characters are dropped here unless they end the expression
    assign infix.ready = !q_full;
    assign q_push      = infix.valid && !q_full
                      && ((q_token.kind != itp_pkg::TK_NONE) || infix.end_of_expr);

endmodule

// ===== rtl/itp_queue.sv =====
module itp_queue (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  itp_pkg::token_t push_token,
    input  logic            pop,
    output itp_pkg::token_t pop_token,
    output logic            full,
    output logic            empty
);

    localparam int PTR_W = $clog2(itp_pkg::QUEUE_DEPTH);
    localparam int CNT_W = $clog2(itp_pkg::QUEUE_DEPTH + 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(itp_pkg::QUEUE_DEPTH);

    itp_pkg::token_t  entry_reg [itp_pkg::QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic             do_push;
    logic             do_pop;

    assign full      = (count_reg == FULL_CNT);
    assign empty     = (count_reg == '0);
    assign do_push   = push && !full;
    assign do_pop    = pop && !empty;
    assign pop_token = entry_reg[rd_ptr_reg];

    // Pointers and fill level
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= wr_ptr_reg + PTR_W'(1);
            end
            if (do_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + PTR_W'(1);
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + CNT_W'(1);
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - CNT_W'(1);
            end
        end
    end

    // Storage
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_token;
        end
    end

endmodule

// ===== rtl/itp_back.sv =====
module itp_back #(
    parameter int STACK_DEPTH
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            power_right_assoc,
    input  itp_pkg::token_t q_token,
    input  logic            q_empty,
    output logic            q_pop,
    itp_out_if.source       postfix
);

    localparam int IDX_W = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam int CNT_W = $clog2(STACK_DEPTH + 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(STACK_DEPTH);

    itp_pkg::back_state_t state_reg;
    itp_pkg::back_state_t state_next;
    itp_pkg::token_t      tok_reg;

    logic [2:0]       op_stack_reg [STACK_DEPTH];
    logic [CNT_W-1:0] count_reg;
    logic             emitted_reg;

    // Pending result: held back until the step ends so that last can be set
    logic             pend_valid_reg;
    logic [7:0]       pend_char_reg;
    logic             pend_cv_reg;
    logic [1:0]       pend_st_reg;

    logic             out_valid_reg;
    logic [7:0]       out_char_reg;
    logic             out_cv_reg;
    logic [1:0]       out_st_reg;
    logic             out_last_reg;

    logic [CNT_W-1:0] cnt_dec;
    logic [2:0]       top_code;
    logic             stack_empty;
    logic             stack_full;
    logic             out_free;
    logic             emit_ok;
    logic             top_pops;
    logic [1:0]       top_prec;
    logic [1:0]       tok_prec;

    logic             emit_now;
    logic [7:0]       emit_char;
    logic             emit_cv;
    logic [1:0]       emit_st;
    logic             do_pop;
    logic             do_push;
    logic [2:0]       push_code;
    logic             final_move;
    logic             out_load;

    // Stack top and flags
    assign cnt_dec     = count_reg - CNT_W'(1);
    assign top_code    = op_stack_reg[cnt_dec[IDX_W-1:0]];
    assign stack_empty = (count_reg == '0);
    assign stack_full  = (count_reg == FULL_CNT);
    assign out_free    = !out_valid_reg || postfix.ready;
    assign emit_ok     = !pend_valid_reg || out_free;
    assign top_prec    = itp_pkg::code_prec(top_code);
    assign tok_prec    = itp_pkg::code_prec(tok_reg.code);
    assign top_pops    = (top_prec > tok_prec)
                      || ((top_prec == tok_prec)
                          && !((tok_reg.code == itp_pkg::CODE_POW) && power_right_assoc));

    // Sequencer: next state and step actions
    always_comb
    begin
        state_next = state_reg;
        q_pop      = 1'b0;
        emit_now   = 1'b0;
        emit_char  = itp_pkg::CHAR_NUL;
        emit_cv    = 1'b0;
        emit_st    = itp_pkg::STATUS_OK;
        do_pop     = 1'b0;
        do_push    = 1'b0;
        push_code  = tok_reg.code;
        final_move = 1'b0;

        case (state_reg)
            itp_pkg::ST_IDLE:
            begin
                if (!q_empty)
                begin
                    q_pop      = 1'b1;
                    state_next = itp_pkg::ST_MAIN;
                end
            end

            itp_pkg::ST_MAIN:
            begin
                case (tok_reg.kind)
                    itp_pkg::TK_LETTER:
                    begin
                        if (emit_ok)
                        begin
                            emit_now   = 1'b1;
                            emit_char  = tok_reg.ch;
                            emit_cv    = 1'b1;
                            state_next = tok_reg.eoe ? itp_pkg::ST_FLUSH : itp_pkg::ST_DONE;
                        end
                    end

                    itp_pkg::TK_OPEN, itp_pkg::TK_OP:
                    begin
                        push_code = (tok_reg.kind == itp_pkg::TK_OPEN)
                                  ? itp_pkg::CODE_OPEN : tok_reg.code;
                        if ((tok_reg.kind == itp_pkg::TK_OP) && !stack_empty
                            && (top_code != itp_pkg::CODE_OPEN) && top_pops)
                        begin
                            // Pop one operator per cycle while emit_ok
                            if (emit_ok)
                            begin
                                emit_now  = 1'b1;
                                emit_char = itp_pkg::code_char(top_code);
                                emit_cv   = 1'b1;
                                do_pop    = 1'b1;
                            end
                        end
                        else if (stack_full)
                        begin
                            if (emit_ok)
                            begin
                                emit_now   = 1'b1;
                                emit_st    = itp_pkg::STATUS_OVERFLOW;
                                state_next = tok_reg.eoe ? itp_pkg::ST_FLUSH
                                                         : itp_pkg::ST_DONE;
                            end
                        end
                        else
                        begin
                            do_push    = 1'b1;
                            state_next = tok_reg.eoe ? itp_pkg::ST_FLUSH : itp_pkg::ST_DONE;
                        end
                    end

                    itp_pkg::TK_CLOSE:
                    begin
                        if (!stack_empty && (top_code != itp_pkg::CODE_OPEN))
                        begin
                            if (emit_ok)
                            begin
                                emit_now  = 1'b1;
                                emit_char = itp_pkg::code_char(top_code);
                                emit_cv   = 1'b1;
                                do_pop    = 1'b1;
                            end
                        end
                        else if (!stack_empty)
                        begin
                            // Drop the matching open bracket
                            do_pop     = 1'b1;
                            state_next = tok_reg.eoe ? itp_pkg::ST_FLUSH : itp_pkg::ST_DONE;
                        end
                        else if (emit_ok)
                        begin
                            emit_now   = 1'b1;
                            emit_st    = itp_pkg::STATUS_BAD_CLOSE;
                            state_next = tok_reg.eoe ? itp_pkg::ST_FLUSH : itp_pkg::ST_DONE;
                        end
                    end

                    default:
                    begin
                        state_next = tok_reg.eoe ? itp_pkg::ST_FLUSH : itp_pkg::ST_DONE;
                    end
                endcase
            end

            itp_pkg::ST_FLUSH:
            begin
                if (stack_empty)
                begin
                    state_next = itp_pkg::ST_DONE;
                end
                else if (emit_ok)
                begin
                    emit_now = 1'b1;
                    do_pop   = 1'b1;
                    if (top_code == itp_pkg::CODE_OPEN)
                    begin
                        emit_st = itp_pkg::STATUS_BAD_OPEN;
                    end
                    else
                    begin
                        emit_char = itp_pkg::code_char(top_code);
                        emit_cv   = 1'b1;
                    end
                end
            end

            itp_pkg::ST_DONE:
            begin
                if (tok_reg.eoe && !emitted_reg)
                begin
                    // Empty end step still yields one status word
                    if (emit_ok)
                    begin
                        emit_now = 1'b1;
                    end
                end
                else if (pend_valid_reg)
                begin
                    if (out_free)
                    begin
                        final_move = 1'b1;
                        state_next = itp_pkg::ST_IDLE;
                    end
                end
                else
                begin
                    state_next = itp_pkg::ST_IDLE;
                end
            end

            default:
            begin
                state_next = itp_pkg::ST_IDLE;
            end
        endcase
    end

    assign out_load = (emit_now && pend_valid_reg) || final_move;

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= itp_pkg::ST_IDLE;
            count_reg      <= '0;
            emitted_reg    <= 1'b0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (do_pop)
            begin
                count_reg <= cnt_dec;
            end
            else if (do_push)
            begin
                count_reg <= count_reg + CNT_W'(1);
            end
            if (q_pop)
            begin
                emitted_reg <= 1'b0;
            end
            else if (emit_now)
            begin
                emitted_reg <= 1'b1;
            end
            if (emit_now)
            begin
                pend_valid_reg <= 1'b1;
            end
            else if (final_move)
            begin
                pend_valid_reg <= 1'b0;
            end
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (postfix.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers and stack storage
    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            tok_reg <= q_token;
        end
        if (do_push)
        begin
            op_stack_reg[count_reg[IDX_W-1:0]] <= push_code;
        end
        if (emit_now)
        begin
            pend_char_reg <= emit_char;
            pend_cv_reg   <= emit_cv;
            pend_st_reg   <= emit_st;
        end
        if (out_load)
        begin
            out_char_reg <= pend_char_reg;
            out_cv_reg   <= pend_cv_reg;
            out_st_reg   <= pend_st_reg;
            out_last_reg <= final_move && tok_reg.eoe;
        end
    end

    assign postfix.valid      = out_valid_reg;
    assign postfix.out_char   = out_char_reg;
    assign postfix.char_valid = out_cv_reg;
    assign postfix.status     = out_st_reg;
    assign postfix.last       = out_last_reg;

`ifndef SYNTHESIS
    // Stack never holds more than its depth
    assert property (@(posedge clk) disable iff (!rst_n) count_reg <= FULL_CNT)
        else $error("stack count beyond depth");

    // Nothing is pending between steps
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == itp_pkg::ST_IDLE) |-> !pend_valid_reg)
        else $error("pending word left over between steps");

    // An expression-ending step leaves the stack empty
    assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == itp_pkg::ST_DONE) && tok_reg.eoe) |-> stack_empty)
        else $error("stack not flushed at end of expression");

    // A pending word is only displaced into a free output register
    assert property (@(posedge clk) disable iff (!rst_n)
        (emit_now && pend_valid_reg) |-> out_free)
        else $error("output register overwritten");

    // The final word of a step shows on the output next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        final_move |=> postfix.valid)
        else $error("final word lost");
`endif

endmodule

// ===== rtl/infix_to_postfix_converter.sv =====
// Shunting-yard infix to postfix converter. The front end takes one character per cycle into
// a four-word token queue, and stalls while the queue is full; the back-end sequencer then
// fetches a token, produces its result words (letters, popped operators, status words) one at
// a time, pushes an operator or drops a bracket, and closes the step. A word carrying the
// end-of-expression flag also flushes the stack entry by entry until it finds the stack
// empty; a full output register stalls the sequencer. The operator stack is STACK_DEPTH
// entries of flip-flops read at the top only; it needs no clearing after reset. Write
// cfg_wr_data (right-associative '^') only while idle.
module infix_to_postfix_converter #(
    parameter int STACK_DEPTH = 16
) (
    input  logic      clk,
    input  logic      rst_n,
    input  logic      cfg_wr_en,
    input  logic      cfg_wr_data,
    itp_in_if.sink    infix,
    itp_out_if.source postfix
);

    logic            power_right_assoc_reg;
    logic            q_push;
    logic            q_pop;
    logic            q_full;
    logic            q_empty;
    itp_pkg::token_t push_token;
    itp_pkg::token_t pop_token;

    // Configuration register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            power_right_assoc_reg <= 1'b0;
        end
        else if (cfg_wr_en)
        begin
            power_right_assoc_reg <= cfg_wr_data;
        end
    end

    itp_front u_front (
        .infix   (infix),
        .q_full  (q_full),
        .q_push  (q_push),
        .q_token (push_token)
    );

    itp_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_token (push_token),
        .pop        (q_pop),
        .pop_token  (pop_token),
        .full       (q_full),
        .empty      (q_empty)
    );

    itp_back #(
        .STACK_DEPTH (STACK_DEPTH)
    ) u_back (
        .clk               (clk),
        .rst_n             (rst_n),
        .power_right_assoc (power_right_assoc_reg),
        .q_token           (pop_token),
        .q_empty           (q_empty),
        .q_pop             (q_pop),
        .postfix           (postfix)
    );

endmodule
